@@ rtl/dct8_pkg.sv @@
// Shared types, widths and register codes for the eight-point Loeffler DCT.
package dct8_pkg;

   localparam int COEF_FRAC_BITS = 14;

   localparam int IN_W   = 16;
   localparam int OUT_W  = 20;
   localparam int CSR_W  = 16;
   localparam int CIDX_W = 3;

   // internal widths, all grown so that no sum or product overflows
   localparam int A_W    = IN_W + 1;
   localparam int B_W    = IN_W + 2;
   localparam int C_W    = IN_W + 3;
   localparam int K_W    = CSR_W + 1;
   localparam int OP_W   = A_W + K_W;
   localparam int OS_W   = OP_W + 2;
   localparam int ROT_W  = OS_W - COEF_FRAC_BITS;
   localparam int EP_W   = B_W + K_W;
   localparam int ES_W   = EP_W + 2;
   localparam int EROT_W = ES_W - COEF_FRAC_BITS;
   localparam int CO_W   = ROT_W + 1;
   localparam int D_W    = ROT_W + 2;
   localparam int SP_W   = CO_W + K_W;
   localparam int SS_W   = SP_W + 1;
   localparam int SC_W   = SS_W - COEF_FRAC_BITS;
   localparam int SAT_W  = 48;

   localparam logic signed [SAT_W-1:0] ROUND_HALF =
      SAT_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [SAT_W-1:0] COEF_MAX = SAT_W'(64'sd524287);
   localparam logic signed [SAT_W-1:0] COEF_MIN = SAT_W'(-64'sd524288);

   // register indexes
   localparam logic [CIDX_W-1:0] CSR_COS_PI_16        = 3'd0;
   localparam logic [CIDX_W-1:0] CSR_SIN_PI_16        = 3'd1;
   localparam logic [CIDX_W-1:0] CSR_COS_3PI_16       = 3'd2;
   localparam logic [CIDX_W-1:0] CSR_SIN_3PI_16       = 3'd3;
   localparam logic [CIDX_W-1:0] CSR_ROOT2_COS_6PI_16 = 3'd4;
   localparam logic [CIDX_W-1:0] CSR_ROOT2_SIN_6PI_16 = 3'd5;
   localparam logic [CIDX_W-1:0] CSR_ROOT_TWO         = 3'd6;

   localparam logic [CSR_W-1:0] RST_COS_PI_16        = 16'd16069;
   localparam logic [CSR_W-1:0] RST_SIN_PI_16        = 16'd3196;
   localparam logic [CSR_W-1:0] RST_COS_3PI_16       = 16'd13623;
   localparam logic [CSR_W-1:0] RST_SIN_3PI_16       = 16'd9102;
   localparam logic [CSR_W-1:0] RST_ROOT2_COS_6PI_16 = 16'd8867;
   localparam logic [CSR_W-1:0] RST_ROOT2_SIN_6PI_16 = 16'd21407;
   localparam logic [CSR_W-1:0] RST_ROOT_TWO         = 16'd23170;

   typedef logic signed [IN_W-1:0]  sample_type;
   typedef logic signed [OUT_W-1:0] coef_type;

   typedef struct packed {
      sample_type in_0;
      sample_type in_1;
      sample_type in_2;
      sample_type in_3;
      sample_type in_4;
      sample_type in_5;
      sample_type in_6;
      sample_type in_7;
   } req_type;

   typedef struct packed {
      coef_type coef_0;
      coef_type coef_1;
      coef_type coef_2;
      coef_type coef_3;
      coef_type coef_4;
      coef_type coef_5;
      coef_type coef_6;
      coef_type coef_7;
   } rsp_type;

   function automatic coef_type sat_coef(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] y;
      y = x;
      if (x > COEF_MAX) begin
         y = COEF_MAX;
      end
      if (x < COEF_MIN) begin
         y = COEF_MIN;
      end
      return y[OUT_W-1:0];
   endfunction

endpackage

@@ rtl/dct8_loeffler_fixed_point.sv @@
// Top level: pipelined eight-point Loeffler DCT-II with programmable rotation constants.
//
// Usage
//   req_valid/req_stall/req_data carry one row of eight 16-bit samples per beat.
//   rsp_valid/rsp_stall/rsp_data carry the eight 20-bit coefficients X0..X7.
//   A beat moves on a rising edge with valid high and stall low.
//   csr_valid/csr_ready/csr_index/csr_data write the seven rotation constants;
//   csr_ready is always high, an index past the list is dropped. Write only
//   while the pipe is empty.
// Timing
//   Six register stages; a row accepted into stage one is offered on rsp
//   once it reaches stage six, the output register.
//   One row per cycle sustained: every stage advances each cycle unless the
//   stage below is full and stalled. Empty stages fill even under stall.
// Stall
//   rsp_stall freezes the output register; the freeze ripples upward only
//   through full stages, and req_stall rises once stage one cannot move.
//   Nothing is dropped or repeated.
// Reset
//   Synchronous, active high: all stages empty, constants back to Q14 defaults.
module dct8_loeffler_fixed_point
   import dct8_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CIDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   localparam int NSTAGE = 6;

   // ---------------------------------------------------------------
   // Constant registers
   // ---------------------------------------------------------------
   logic [CSR_W-1:0] cos1_ff, sin1_ff, cos3_ff, sin3_ff, rcos_ff, rsin_ff, rtwo_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos1_ff <= RST_COS_PI_16;
         sin1_ff <= RST_SIN_PI_16;
         cos3_ff <= RST_COS_3PI_16;
         sin3_ff <= RST_SIN_3PI_16;
         rcos_ff <= RST_ROOT2_COS_6PI_16;
         rsin_ff <= RST_ROOT2_SIN_6PI_16;
         rtwo_ff <= RST_ROOT_TWO;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COS_PI_16:        cos1_ff <= csr_data;
            CSR_SIN_PI_16:        sin1_ff <= csr_data;
            CSR_COS_3PI_16:       cos3_ff <= csr_data;
            CSR_SIN_3PI_16:       sin3_ff <= csr_data;
            CSR_ROOT2_COS_6PI_16: rcos_ff <= csr_data;
            CSR_ROOT2_SIN_6PI_16: rsin_ff <= csr_data;
            CSR_ROOT_TWO:         rtwo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // constants as positive signed operands
   logic signed [K_W-1:0] k_cos1, k_sin1, k_cos3, k_sin3, k_rcos, k_rsin, k_rtwo;
   assign k_cos1 = $signed({1'b0, cos1_ff});
   assign k_sin1 = $signed({1'b0, sin1_ff});
   assign k_cos3 = $signed({1'b0, cos3_ff});
   assign k_sin3 = $signed({1'b0, sin3_ff});
   assign k_rcos = $signed({1'b0, rcos_ff});
   assign k_rsin = $signed({1'b0, rsin_ff});
   assign k_rtwo = $signed({1'b0, rtwo_ff});

   // ---------------------------------------------------------------
   // Flow control: a stage moves when empty or when the next one moves
   // ---------------------------------------------------------------
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] adv;

   always_comb begin
      adv[NSTAGE-1] = !vld_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: input butterflies
   // ---------------------------------------------------------------
   logic signed [A_W-1:0] a0_ff, a1_ff, a2_ff, a3_ff, a4_ff, a5_ff, a6_ff, a7_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a0_ff <= A_W'(req_data.in_0) + A_W'(req_data.in_7);
         a1_ff <= A_W'(req_data.in_1) + A_W'(req_data.in_6);
         a2_ff <= A_W'(req_data.in_2) + A_W'(req_data.in_5);
         a3_ff <= A_W'(req_data.in_3) + A_W'(req_data.in_4);
         a4_ff <= A_W'(req_data.in_3) - A_W'(req_data.in_4);
         a5_ff <= A_W'(req_data.in_2) - A_W'(req_data.in_5);
         a6_ff <= A_W'(req_data.in_1) - A_W'(req_data.in_6);
         a7_ff <= A_W'(req_data.in_0) - A_W'(req_data.in_7);
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: even butterflies, odd rotation products
   // ---------------------------------------------------------------
   logic signed [B_W-1:0]  b0_ff, b1_ff, b2_ff, b3_ff;
   logic signed [OP_W-1:0] p4c_ff, p7s_ff, p4s_ff, p7c_ff;
   logic signed [OP_W-1:0] p5c_ff, p6s_ff, p5s_ff, p6c_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b0_ff  <= B_W'(a0_ff) + B_W'(a3_ff);
         b1_ff  <= B_W'(a1_ff) + B_W'(a2_ff);
         b2_ff  <= B_W'(a1_ff) - B_W'(a2_ff);
         b3_ff  <= B_W'(a0_ff) - B_W'(a3_ff);
         p4c_ff <= OP_W'(a4_ff) * OP_W'(k_cos3);
         p7s_ff <= OP_W'(a7_ff) * OP_W'(k_sin3);
         p4s_ff <= OP_W'(a4_ff) * OP_W'(k_sin3);
         p7c_ff <= OP_W'(a7_ff) * OP_W'(k_cos3);
         p5c_ff <= OP_W'(a5_ff) * OP_W'(k_cos1);
         p6s_ff <= OP_W'(a6_ff) * OP_W'(k_sin1);
         p5s_ff <= OP_W'(a5_ff) * OP_W'(k_sin1);
         p6c_ff <= OP_W'(a6_ff) * OP_W'(k_cos1);
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: DC/Nyquist butterfly, even products, odd rotations rounded
   // ---------------------------------------------------------------
   logic signed [OS_W-1:0]  s4_in, s7_in, s5_in, s6_in;
   logic signed [C_W-1:0]   c0_ff, c1_ff;
   logic signed [EP_W-1:0]  q2c_ff, q3s_ff, q2s_ff, q3c_ff;
   logic signed [ROT_W-1:0] r4_ff, r5_ff, r6_ff, r7_ff;

   always_comb begin
      s4_in = OS_W'(p4c_ff) + OS_W'(p7s_ff) + OS_W'(ROUND_HALF);
      s7_in = OS_W'(p7c_ff) - OS_W'(p4s_ff) + OS_W'(ROUND_HALF);
      s5_in = OS_W'(p5c_ff) + OS_W'(p6s_ff) + OS_W'(ROUND_HALF);
      s6_in = OS_W'(p6c_ff) - OS_W'(p5s_ff) + OS_W'(ROUND_HALF);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         c0_ff  <= C_W'(b0_ff) + C_W'(b1_ff);
         c1_ff  <= C_W'(b0_ff) - C_W'(b1_ff);
         q2c_ff <= EP_W'(b2_ff) * EP_W'(k_rcos);
         q3s_ff <= EP_W'(b3_ff) * EP_W'(k_rsin);
         q2s_ff <= EP_W'(b2_ff) * EP_W'(k_rsin);
         q3c_ff <= EP_W'(b3_ff) * EP_W'(k_rcos);
         r4_ff  <= ROT_W'(s4_in >>> COEF_FRAC_BITS);
         r7_ff  <= ROT_W'(s7_in >>> COEF_FRAC_BITS);
         r5_ff  <= ROT_W'(s5_in >>> COEF_FRAC_BITS);
         r6_ff  <= ROT_W'(s6_in >>> COEF_FRAC_BITS);
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: even rotation rounded, odd butterflies
   // ---------------------------------------------------------------
   logic signed [ES_W-1:0]   e2_in, e3_in;
   logic signed [C_W-1:0]    c0_s4_ff, c1_s4_ff;
   logic signed [EROT_W-1:0] c2_ff, c3_ff;
   logic signed [CO_W-1:0]   c4_ff, c5_ff, c6_ff, c7_ff;

   always_comb begin
      e2_in = ES_W'(q2c_ff) + ES_W'(q3s_ff) + ES_W'(ROUND_HALF);
      e3_in = ES_W'(q3c_ff) - ES_W'(q2s_ff) + ES_W'(ROUND_HALF);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         c0_s4_ff <= c0_ff;
         c1_s4_ff <= c1_ff;
         c2_ff    <= EROT_W'(e2_in >>> COEF_FRAC_BITS);
         c3_ff    <= EROT_W'(e3_in >>> COEF_FRAC_BITS);
         c4_ff    <= CO_W'(r4_ff) + CO_W'(r6_ff);
         c5_ff    <= CO_W'(r7_ff) - CO_W'(r5_ff);
         c6_ff    <= CO_W'(r4_ff) - CO_W'(r6_ff);
         c7_ff    <= CO_W'(r7_ff) + CO_W'(r5_ff);
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: root-two products, last odd butterfly
   // ---------------------------------------------------------------
   logic signed [C_W-1:0]    c0_s5_ff, c1_s5_ff;
   logic signed [EROT_W-1:0] c2_s5_ff, c3_s5_ff;
   logic signed [SP_W-1:0]   m5_ff, m6_ff;
   logic signed [D_W-1:0]    d4_ff, d7_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         c0_s5_ff <= c0_s4_ff;
         c1_s5_ff <= c1_s4_ff;
         c2_s5_ff <= c2_ff;
         c3_s5_ff <= c3_ff;
         m5_ff    <= SP_W'(c5_ff) * SP_W'(k_rtwo);
         m6_ff    <= SP_W'(c6_ff) * SP_W'(k_rtwo);
         d4_ff    <= D_W'(c7_ff) - D_W'(c4_ff);
         d7_ff    <= D_W'(c7_ff) + D_W'(c4_ff);
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: round the scaled terms, saturate, output register
   // ---------------------------------------------------------------
   logic signed [SS_W-1:0] m5_in, m6_in;
   logic signed [SC_W-1:0] d5_in, d6_in;
   rsp_type                out_ff;

   always_comb begin
      m5_in = SS_W'(m5_ff) + SS_W'(ROUND_HALF);
      m6_in = SS_W'(m6_ff) + SS_W'(ROUND_HALF);
      d5_in = SC_W'(m5_in >>> COEF_FRAC_BITS);
      d6_in = SC_W'(m6_in >>> COEF_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         out_ff.coef_0 <= sat_coef(SAT_W'(c0_s5_ff));
         out_ff.coef_1 <= sat_coef(SAT_W'(d7_ff));
         out_ff.coef_2 <= sat_coef(SAT_W'(c2_s5_ff));
         out_ff.coef_3 <= sat_coef(SAT_W'(d5_in));
         out_ff.coef_4 <= sat_coef(SAT_W'(c1_s5_ff));
         out_ff.coef_5 <= sat_coef(SAT_W'(d6_in));
         out_ff.coef_6 <= sat_coef(SAT_W'(c3_s5_ff));
         out_ff.coef_7 <= sat_coef(SAT_W'(d4_ff));
      end
   end

   assign rsp_valid = vld_ff[NSTAGE-1];
   assign rsp_data  = out_ff;

endmodule

@@ rtl/dct8_chk.sv @@
// Port-level assertions for the DCT pipeline, bound to the top level.
module dct8_chk
   import dct8_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rsp_type           rsp_data,
   input logic              csr_valid,
   input logic              csr_ready
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped under stall");

   // and keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp payload changed under stall");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // empty output stage means every stage can move
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty output");

   // constant registers never back-pressure
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr not ready");

endmodule

bind dct8_loeffler_fixed_point dct8_chk u_dct8_chk (.*);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the eight-point Loeffler DCT.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dct8_pkg::*;

   localparam int NUM_CSR = 7;
   // first index past the register list; a write there must be dropped
   localparam logic [CIDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam longint COEF_HI = 524287;
   localparam longint COEF_LO = -524288;

   // cycles with no beat on any channel before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // quiet cycles after the last outstanding row, longer than the six-stage pipe
   localparam int PIPE_SETTLE = 8;
   localparam int END_SETTLE = 16;
   localparam int ROWS_PER_PHASE = 198;

   // ------------------------------------------------------------------
   // DUT ports; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CIDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]  csr_data = '0;

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   int idle_pct = 0;     // chance per cycle that the row sender holds off
   int stall_pct = 0;    // chance per cycle that the coefficient sink stalls
   int errors = 0;
   int quiet_cycles = 0;

   // coefficients owed by the DUT, oldest first
   rsp_type pending_coefs [$];
   // our own copy of the rotation constants, kept in step with every write
   logic [CSR_W-1:0] csr_shadow [NUM_CSR];

   dct8_loeffler_fixed_point u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Coefficient predictor
   // ------------------------------------------------------------------

   // round half up, then arithmetic shift down to integer
   function automatic longint round_q(input longint x);
      return (x + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
   endfunction

   // one output of a plane rotation: round(a*ka + b*kb)
   function automatic longint rot_term(input longint a, input longint ka,
                                       input longint b, input longint kb);
      return round_q(a * ka + b * kb);
   endfunction

   function automatic coef_type clip_coef(input longint x);
      longint y;
      y = x;
      if (y > COEF_HI) y = COEF_HI;
      if (y < COEF_LO) y = COEF_LO;
      return coef_type'(y);
   endfunction

   // Full Loeffler flow graph on exact 64-bit values; only the final
   // coefficients are clipped to 20 bits.
   function automatic rsp_type dct_coefs(input req_type row);
      logic [8*IN_W-1:0] flat;
      longint x [8];
      longint kc1, ks1, kc3, ks3, kc6, ks6, kr2;
      longint a0, a1, a2, a3, a4, a5, a6, a7;
      longint b0, b1, b2, b3, b4, b5, b6, b7;
      longint c0, c1, c2, c3, c4, c5, c6, c7;
      longint d4, d5, d6, d7;
      int i;
      flat = row;
      for (i = 0; i < 8; i++) begin
         x[i] = longint'(sample_type'(flat[(7-i)*IN_W +: IN_W]));
      end
      kc1 = longint'(csr_shadow[CSR_COS_PI_16]);
      ks1 = longint'(csr_shadow[CSR_SIN_PI_16]);
      kc3 = longint'(csr_shadow[CSR_COS_3PI_16]);
      ks3 = longint'(csr_shadow[CSR_SIN_3PI_16]);
      kc6 = longint'(csr_shadow[CSR_ROOT2_COS_6PI_16]);
      ks6 = longint'(csr_shadow[CSR_ROOT2_SIN_6PI_16]);
      kr2 = longint'(csr_shadow[CSR_ROOT_TWO]);

      // butterflies
      a0 = x[0] + x[7];  a1 = x[1] + x[6];
      a2 = x[2] + x[5];  a3 = x[3] + x[4];
      a4 = x[3] - x[4];  a5 = x[2] - x[5];
      a6 = x[1] - x[6];  a7 = x[0] - x[7];

      // even butterflies, odd rotations of (4,7) and (5,6)
      b0 = a0 + a3;  b1 = a1 + a2;
      b2 = a1 - a2;  b3 = a0 - a3;
      b4 = rot_term(a4, kc3, a7, ks3);
      b7 = rot_term(a4, -ks3, a7, kc3);
      b5 = rot_term(a5, kc1, a6, ks1);
      b6 = rot_term(a5, -ks1, a6, kc1);

      // last even butterfly, root-two rotation of (2,3), odd butterflies
      c0 = b0 + b1;  c1 = b0 - b1;
      c2 = rot_term(b2, kc6, b3, ks6);
      c3 = rot_term(b2, -ks6, b3, kc6);
      c4 = b4 + b6;  c5 = b7 - b5;
      c6 = b4 - b6;  c7 = b7 + b5;

      // last odd butterfly and root-two scaling
      d4 = c7 - c4;
      d5 = round_q(c5 * kr2);
      d6 = round_q(c6 * kr2);
      d7 = c7 + c4;

      return rsp_type'({clip_coef(c0), clip_coef(d7), clip_coef(c2), clip_coef(d5),
                        clip_coef(c1), clip_coef(d6), clip_coef(c3), clip_coef(d4)});
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Samples lean on the edges: full-range noise, rails, tiny values for
   // the rounding, and repeats so that butterfly differences go to zero.
   function automatic req_type random_row();
      logic [8*IN_W-1:0] flat;
      logic [IN_W-1:0] s, prev;
      int i;
      prev = '0;
      for (i = 0; i < 8; i++) begin
         case ($urandom_range(0, 9))
            5: s = 16'h7FFF;
            6: s = 16'h8000;
            7: s = IN_W'(int'($urandom_range(0, 8)) - 4);
            8: s = ($urandom_range(0, 1) != 0) ? '1 : '0;
            9: s = prev;
            default: s = IN_W'($urandom);
         endcase
         prev = s;
         flat[(7-i)*IN_W +: IN_W] = s;
      end
      return req_type'(flat);
   endfunction

   // near the Q14 value as often as full-range, with rails mixed in
   function automatic logic [CSR_W-1:0] pick_csr(input logic [CSR_W-1:0] dflt);
      case ($urandom_range(0, 9)) inside
         0: return '0;
         1: return '1;
         [2:5]: return CSR_W'($urandom);
         default: return dflt + CSR_W'($urandom_range(0, 1023)) - CSR_W'(512);
      endcase
   endfunction

   // Offer one row and hold it until the beat is taken. Valid stays high
   // afterwards so back-to-back rows go out with no idle gap between them.
   task automatic send_row(input req_type row);
      int gap;
      gap = 0;
      while (idle_pct != 0 && gap < 12 && $urandom_range(0, 99) < idle_pct) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row;
      do @(posedge clock); while (req_stall);
      pending_coefs.push_back(dct_coefs(row));
   endtask

   // Stop sending and let the pipe empty before touching the constants.
   task automatic drain_rows();
      req_valid <= 1'b0;
      while (pending_coefs.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CIDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_CSR) csr_shadow[idx] = val;
   endtask

   task automatic load_csrs(input logic [CSR_W-1:0] c1, input logic [CSR_W-1:0] s1,
                            input logic [CSR_W-1:0] c3, input logic [CSR_W-1:0] s3,
                            input logic [CSR_W-1:0] rc6, input logic [CSR_W-1:0] rs6,
                            input logic [CSR_W-1:0] r2);
      write_csr(CSR_COS_PI_16, c1);
      write_csr(CSR_SIN_PI_16, s1);
      write_csr(CSR_COS_3PI_16, c3);
      write_csr(CSR_SIN_3PI_16, s3);
      write_csr(CSR_ROOT2_COS_6PI_16, rc6);
      write_csr(CSR_ROOT2_SIN_6PI_16, rs6);
      write_csr(CSR_ROOT_TWO, r2);
      csr_valid <= 1'b0;
   endtask

   task automatic load_defaults();
      load_csrs(RST_COS_PI_16, RST_SIN_PI_16, RST_COS_3PI_16, RST_SIN_3PI_16,
                RST_ROOT2_COS_6PI_16, RST_ROOT2_SIN_6PI_16, RST_ROOT_TWO);
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 200) $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_coefs(input rsp_type got, input rsp_type want);
      logic [8*OUT_W-1:0] g, w;
      int k;
      g = got;
      w = want;
      for (k = 0; k < 8; k++) begin
         if (g[(7-k)*OUT_W +: OUT_W] !== w[(7-k)*OUT_W +: OUT_W]) begin
            report_mismatch($sformatf("coef_%0d got %0d want %0d", k,
                                      coef_type'(g[(7-k)*OUT_W +: OUT_W]),
                                      coef_type'(w[(7-k)*OUT_W +: OUT_W])));
         end
      end
   endtask

   // every coefficient beat is matched against the oldest owed row
   always @(posedge clock) begin : coef_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_coefs.size() == 0) begin
            report_mismatch("coefficient beat with no row outstanding");
         end else begin
            want = pending_coefs.pop_front();
            check_coefs(rsp_data, want);
         end
      end
   end

   // sink back-pressure, redrawn each cycle
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // hang detector: any beat on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("dct8_loeffler_fixed_point: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Rails, sign patterns that excite X1..X7 hardest, an impulse at each
   // position, and small negatives that exercise rounding of negatives.
   task automatic test_directed_rows();
      logic [8*IN_W-1:0] flat;
      int i;
      idle_pct  = 0;
      stall_pct = 0;
      send_row(req_type'({8{16'h0000}}));
      send_row(req_type'({8{16'h7FFF}}));
      send_row(req_type'({8{16'h8000}}));
      send_row(req_type'({4{16'h7FFF, 16'h8000}}));
      send_row(req_type'({4{16'h8000, 16'h7FFF}}));
      for (i = 0; i < 8; i++) begin
         flat = '0;
         flat[(7-i)*IN_W +: IN_W] = (i % 2 == 0) ? 16'h7FFF : 16'h8000;
         send_row(req_type'(flat));
      end
      send_row(req_type'({16'h8000, 16'hA000, 16'hC000, 16'hE000,
                          16'h2000, 16'h4000, 16'h6000, 16'h7FFF}));
      send_row(req_type'({8{16'hFFFF}}));
      send_row(req_type'({4{16'h0001, 16'hFFFF}}));
   endtask

   task automatic rows_for_setting();
      int i;
      send_row(req_type'({8{16'h7FFF}}));
      send_row(req_type'({8{16'h8000}}));
      send_row(req_type'({4{16'h7FFF, 16'h8000}}));
      send_row(req_type'({2{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}}));
      for (i = 0; i < 3; i++) send_row(random_row());
   endtask

   // Constants at their rails, which can drive the coefficients into saturation; then writes past the list.
   task automatic test_csr_extremes();
      idle_pct  = 29;
      stall_pct = 29;
      drain_rows();
      load_csrs('0, '0, '0, '0, '0, '0, '0);
      rows_for_setting();
      drain_rows();
      load_csrs('1, '1, '1, '1, '1, '1, '1);
      rows_for_setting();
      drain_rows();
      load_csrs('1, '0, '1, '0, '1, '0, '1);
      rows_for_setting();
      drain_rows();
      load_csrs('0, '1, '0, '1, '0, '1, '0);
      rows_for_setting();
      // an index past the list must leave every constant alone
      drain_rows();
      write_csr(CSR_UNUSED, CSR_W'($urandom));
      csr_valid <= 1'b0;
      rows_for_setting();
      drain_rows();
      write_csr(CSR_UNUSED, '0);
      load_defaults();
      rows_for_setting();
   endtask

   // Four phases with differing sender idling and sink stalls, each with its own constant set.
   task automatic test_random_traffic();
      int phase, n;
      for (phase = 0; phase < 4; phase++) begin
         drain_rows();
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         if (phase == 0) begin
            load_defaults();
         end else begin
            load_csrs(pick_csr(RST_COS_PI_16), pick_csr(RST_SIN_PI_16),
                      pick_csr(RST_COS_3PI_16), pick_csr(RST_SIN_3PI_16),
                      pick_csr(RST_ROOT2_COS_6PI_16), pick_csr(RST_ROOT2_SIN_6PI_16),
                      pick_csr(RST_ROOT_TWO));
         end
         for (n = 0; n < ROWS_PER_PHASE; n++) send_row(random_row());
      end
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      // shadow starts at the reset values of the DUT
      csr_shadow[CSR_COS_PI_16]        = RST_COS_PI_16;
      csr_shadow[CSR_SIN_PI_16]        = RST_SIN_PI_16;
      csr_shadow[CSR_COS_3PI_16]       = RST_COS_3PI_16;
      csr_shadow[CSR_SIN_3PI_16]       = RST_SIN_3PI_16;
      csr_shadow[CSR_ROOT2_COS_6PI_16] = RST_ROOT2_COS_6PI_16;
      csr_shadow[CSR_ROOT2_SIN_6PI_16] = RST_ROOT2_SIN_6PI_16;
      csr_shadow[CSR_ROOT_TWO]         = RST_ROOT_TWO;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_rows();
      test_csr_extremes();
      test_random_traffic();

      drain_rows();
      repeat (END_SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("dct8_loeffler_fixed_point: match");
      end else begin
         $display("dct8_loeffler_fixed_point: mismatch");
      end
      $finish;
   end

endmodule
